@@ rtl/mric_pkg.sv @@
// Package for the mixed-radix index converter: pipeline types and constants,
// used by mric_stage and the top level, and the step function that mric_stage calls.
// Depends on nothing.
`default_nettype none

package mric_pkg;

    // Number of physical dimensions and the upper bound on the dimension count.
    localparam int unsigned PHYS_DIMS  = 4;
    localparam int unsigned MAX_DIMS   = 4;

    // Stage layout: set-up stages, then eight four-bit division stages per dimension.
    localparam int unsigned SETUP_STAGES = 4;
    localparam int unsigned BITS_PER_DIV = 4;
    localparam int unsigned DIV_STAGES   = 32 / BITS_PER_DIV;
    localparam int unsigned NUM_STAGES   = SETUP_STAGES + PHYS_DIMS * DIV_STAGES + 1;
    localparam int unsigned LAST_STAGE   = NUM_STAGES - 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_NUM_DIMS = 3'd0;
    localparam logic [2:0] REG_DIM_0    = 3'd1;
    localparam logic [2:0] REG_DIM_1    = 3'd2;
    localparam logic [2:0] REG_DIM_2    = 3'd3;
    localparam logic [2:0] REG_DIM_3    = 3'd4;

    // Function codes.
    localparam logic FUNC_IND2SUB = 1'b0;
    localparam logic FUNC_SUB2IND = 1'b1;

    localparam logic [32:0] SAT_33  = 33'h1_0000_0000;
    localparam logic [34:0] MAX_LIN = 35'h0_FFFF_FFFF;

    // Configuration as seen by every stage; nd is already clamped to 1..4.
    typedef struct packed {
        logic [2:0]       nd;
        logic [3:0][15:0] sz;
    } cfg_t;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic             func;
        logic [31:0]      lin;
        logic [3:0][15:0] sub;
        logic             err;
        logic [32:0]      m;
        logic [32:0]      st;
        logic [32:0]      t1;
        logic [32:0]      t2;
        logic [32:0]      t3;
        logic [34:0]      acc;
        logic [31:0]      num;
        logic [15:0]      rem;
    } stage_t;

    // Clamp a 64-bit product to 33 bits; anything at or above 2^32 is overflow.
    function automatic logic [32:0] sat33(input logic [63:0] x);
        logic [32:0] r;
        r = (x > 64'h0000_0000_FFFF_FFFF) ? SAT_33 : x[32:0];
        return r;
    endfunction

    // Work done by pipeline stage k on one item.
    function automatic stage_t stage_step(input int unsigned k, input stage_t s,
                                          input cfg_t c);
        stage_t           o;
        logic [3:0]       used;
        logic [3:0][15:0] sm;
        logic [3:0][15:0] f;
        logic [16:0]      r;
        logic             q;
        logic [1:0]       dim;
        logic [15:0]      dv;
        int unsigned      j;
        o = s;
        for (int d = 0; d < 4; d++)
        begin
            used[d] = (3'(d) < c.nd);
            sm[d]   = used[d] ? (s.sub[d] - 16'd1) : 16'd0;
            f[d]    = used[d] ? c.sz[d] : 16'd1;
        end
        j   = (k >= SETUP_STAGES) ? (k - SETUP_STAGES) : 0;
        dim = 2'(j >> 3);
        dv  = f[dim];
        r   = '0;
        q   = 1'b0;
        if (k == 0)
        begin
            // Subscript range checks and first products.
            o.err = 1'b0;
            for (int d = 0; d < 4; d++)
            begin
                if (s.func == FUNC_SUB2IND && used[d] &&
                    (s.sub[d] == 16'd0 || s.sub[d] > c.sz[d]))
                begin
                    o.err = 1'b1;
                end
            end
            o.m   = 33'({16'd0, f[0]} * {16'd0, f[1]});
            o.st  = 33'({16'd0, c.sz[0]} * {16'd0, c.sz[1]});
            o.t1  = 33'({16'd0, sm[1]} * {16'd0, c.sz[0]});
            o.t2  = '0;
            o.t3  = '0;
            o.acc = '0;
            o.num = '0;
            o.rem = '0;
        end
        else if (k == 1)
        begin
            o.m  = sat33({31'd0, s.m} * {48'd0, f[2]});
            o.t2 = sat33({48'd0, sm[2]} * {31'd0, s.st});
            o.st = sat33({31'd0, s.st} * {48'd0, c.sz[2]});
        end
        else if (k == 2)
        begin
            o.m   = sat33({31'd0, s.m} * {48'd0, f[3]});
            o.t3  = sat33({48'd0, sm[3]} * {31'd0, s.st});
            o.acc = 35'd1 + 35'(sm[0]) + 35'(s.t1) + 35'(s.t2);
        end
        else if (k == 3)
        begin
            // Final sum and overflow check, or index range check.
            if (s.func == FUNC_SUB2IND)
            begin
                o.acc = s.acc + 35'(s.t3);
                if (o.acc > MAX_LIN)
                begin
                    o.err = 1'b1;
                end
            end
            else
            begin
                o.err = (s.lin == 32'd0) || ({1'b0, s.lin} > s.m);
            end
            o.num = s.lin - 32'd1;
            o.rem = '0;
        end
        else if (k < LAST_STAGE)
        begin
            // Four steps of restoring division by the size of dimension dim.
            for (int b = 0; b < BITS_PER_DIV; b++)
            begin
                r = {o.rem, o.num[31]};
                q = (r >= {1'b0, dv});
                if (q)
                begin
                    r = r - {1'b0, dv};
                end
                o.rem = r[15:0];
                o.num = {o.num[30:0], q};
            end
            if (j[2:0] == 3'd7)
            begin
                if (s.func == FUNC_IND2SUB && used[dim])
                begin
                    o.sub[dim] = o.rem + 16'd1;
                end
                o.rem = '0;
            end
        end
        else
        begin
            // Output formatting.
            if (s.err)
            begin
                o.lin = '0;
                o.sub = '0;
            end
            else
            begin
                if (s.func == FUNC_SUB2IND)
                begin
                    o.lin = s.acc[31:0];
                end
                for (int d = 0; d < 4; d++)
                begin
                    if (!used[d])
                    begin
                        o.sub[d] = 16'd1;
                    end
                end
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mric_stage.sv @@
// One register stage of the converter pipeline with its valid bit.
// Depends on mric_pkg.
`default_nettype none

module mric_stage #(
    parameter int unsigned STAGE = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mric_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mric_pkg::stage_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mric_pkg::stage_t     out_data
);

    logic             valid_reg;
    mric_pkg::stage_t data_reg;

    // The stage takes a new item when it is empty or its content moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, loaded on each transfer into the stage.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= mric_pkg::stage_step(STAGE, in_data, cfg);
        end
    end

endmodule

`default_nettype wire

@@ rtl/mixed_radix_index_converter.sv @@
// Top level of the mixed-radix index converter: configuration registers
// and the pipeline of mric_stage instances. Depends on mric_pkg and mric_stage.
//
// Usage: the slave stream carries one request per transfer; s_tuser is the
// function (0 = linear index to subscripts, 1 = subscripts to index) and
// s_tdata holds the index and the four subscripts. The master stream returns
// one result per request, in order, with the range error flag on m_tuser.
// Configuration is written through cfg_we/cfg_index/cfg_data while no
// request is in flight.
// The pipeline has 37 register stages: four set-up stages for the size
// products, strides and checks, 32 stages of a four-bit-per-stage restoring
// divider (eight per dimension), and one output stage. It takes one item
// per cycle while the receiver accepts results.
// Reset clears all valid bits and sets one dimension of size one.
// When the receiver stalls, items close up behind the output stage and the
// input stays ready while any stage is empty; nothing is lost or repeated.
`default_nettype none

module mixed_radix_index_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // lin_index, sub_0, sub_1, sub_2, sub_3
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // lin_index_out, sub_out_0..sub_out_3
    output logic             m_tuser,   // range_error
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int unsigned N = mric_pkg::NUM_STAGES;

    logic [2:0]       num_dims_reg;
    logic [3:0][15:0] dim_size_reg;
    mric_pkg::cfg_t   cfg;
    mric_pkg::stage_t in_item;

    logic             v   [N+1];
    logic             rdy [N+1];
    mric_pkg::stage_t dat [N+1];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= 3'd1;
            dim_size_reg <= {4{16'd1}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mric_pkg::REG_NUM_DIMS: num_dims_reg    <= cfg_data[2:0];
                mric_pkg::REG_DIM_0:    dim_size_reg[0] <= cfg_data;
                mric_pkg::REG_DIM_1:    dim_size_reg[1] <= cfg_data;
                mric_pkg::REG_DIM_2:    dim_size_reg[2] <= cfg_data;
                mric_pkg::REG_DIM_3:    dim_size_reg[3] <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Dimension count clamped to the supported range.
    always_comb
    begin
        cfg.sz = dim_size_reg;
        if (num_dims_reg == 3'd0)
        begin
            cfg.nd = 3'd1;
        end
        else if (num_dims_reg > 3'(mric_pkg::MAX_DIMS))
        begin
            cfg.nd = 3'(mric_pkg::MAX_DIMS);
        end
        else
        begin
            cfg.nd = num_dims_reg;
        end
    end

    // Unpack the request into the pipeline record.
    always_comb
    begin
        in_item        = '0;
        in_item.func   = s_tuser;
        in_item.lin    = s_tdata[31:0];
        in_item.sub[0] = s_tdata[47:32];
        in_item.sub[1] = s_tdata[63:48];
        in_item.sub[2] = s_tdata[79:64];
        in_item.sub[3] = s_tdata[95:80];
    end

    assign v[0]     = s_tvalid;
    assign dat[0]   = in_item;
    assign s_tready = rdy[0];

    // Pipeline stages.
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        mric_stage #(
            .STAGE (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .in_valid  (v[k]),
            .in_ready  (rdy[k]),
            .in_data   (dat[k]),
            .out_valid (v[k+1]),
            .out_ready (rdy[k+1]),
            .out_data  (dat[k+1])
        );
    end

    // Result stream.
    assign rdy[N]   = m_tready;
    assign m_tvalid = v[N];
    assign m_tdata  = {dat[N].sub[3], dat[N].sub[2], dat[N].sub[1], dat[N].sub[0],
                       dat[N].lin};
    assign m_tuser  = dat[N].err;

endmodule

`default_nettype wire

@@ rtl/mric_checker.sv @@
// Port-level checker for the mixed-radix index converter, with its bind.
// Depends on the top level's port list only.
`default_nettype none

module mric_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An error result carries all-zero data.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 96'd0)
        else $error("error result with nonzero data");

    // A good result has a one-based index and first subscript.
    a_one_based: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[31:0] != 32'd0 && m_tdata[47:32] != 16'd0)
        else $error("good result with a zero index or subscript");

    // With the output empty the whole pipeline can move, so input is ready.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind mixed_radix_index_converter mric_checker u_mric_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
